// ===== rtl/mfdf_pkg.sv =====
// ============================================================================
// mfdf_pkg - shared types and constants of the mesh flood duplicate filter
// Status codes, register indexes, reset values, controller states and the
// control bundle that drives the ring of ID cells.
// ============================================================================
package mfdf_pkg;

  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int TYPE_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int HOLDOFF_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_TYPE = 2'd2;

  // Register reset values
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST   = 16'd500;
  localparam logic [TYPE_W-1:0]    SET_TYPE_RST  = 8'd0;
  localparam logic [TYPE_W-1:0]    SYNC_TYPE_RST = 8'd1;

  // Input operation codes
  localparam logic OP_RX        = 1'b0;
  localparam logic OP_LOCAL_SET = 1'b1;

  typedef enum logic [2:0] {
    ST_SET_APPLIED  = 3'd0,
    ST_SYNC_APPLIED = 3'd1,
    ST_SYNC_HELD    = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_BAD_LENGTH   = 3'd4,
    ST_UNKNOWN      = 3'd5,
    ST_LOCAL_SET    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  // Control bundle from the controller to the ring
  typedef struct packed {
    logic            shift;
    logic            wr_en;
    logic [ID_W-1:0] wr_id;
  } ring_ctrl_t;

  // One accepted input beat
  typedef struct packed {
    logic               op;
    logic               length_ok;
    logic [TYPE_W-1:0]  msg_type;
    logic [COLOR_W-1:0] color_value;
    logic [ID_W-1:0]    message_id;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  // One result beat
  typedef struct packed {
    status_e            status;
    logic               apply_color;
    logic [COLOR_W-1:0] color_out;
    logic               rebroadcast;
  } res_t;

endpackage

// ===== rtl/mfdf_if.sv =====
// ============================================================================
// mfdf_if - handshake channels of the mesh flood duplicate filter
// Input message channel and result channel, valid/ready with payload.
// ============================================================================
interface mfdf_in_if
  import mfdf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic               length_ok;
  logic [TYPE_W-1:0]  msg_type;
  logic [COLOR_W-1:0] color_value;
  logic [ID_W-1:0]    message_id;
  logic [TIME_W-1:0]  now_ms;

  modport source (
    output valid, op, length_ok, msg_type, color_value, message_id, now_ms,
    input  ready
  );
  modport sink (
    input  valid, op, length_ok, msg_type, color_value, message_id, now_ms,
    output ready
  );
endinterface

interface mfdf_out_if
  import mfdf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               apply_color;
  logic [COLOR_W-1:0] color_out;
  logic               rebroadcast;

  modport source (
    output valid, status, apply_color, color_out, rebroadcast,
    input  ready
  );
  modport sink (
    input  valid, status, apply_color, color_out, rebroadcast,
    output ready
  );
endinterface

// ===== rtl/mfdf_cell.sv =====
// ============================================================================
// mfdf_cell - one ID cell of the ring
// Holds one stored message ID; loads the neighbor's ID on shift, or a new
// ID on a direct write.
// ============================================================================
module mfdf_cell
  import mfdf_pkg::*;
(
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic [ID_W-1:0] shift_id_i,
  input  logic            wr_en_i,
  input  logic [ID_W-1:0] wr_id_i,
  output logic [ID_W-1:0] id_o
);

  logic [ID_W-1:0] id_d, id_q;

  always_comb begin
    id_d = id_q;
    if (wr_en_i) begin
      id_d = wr_id_i;
    end else if (shift_i) begin
      id_d = shift_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

// ===== rtl/mfdf_ring.sv =====
// ============================================================================
// mfdf_ring - ring of ID cells
// Rotates the stored IDs one cell per shift so that every cell passes the
// head in turn; decodes a direct write to one cell.
// ============================================================================
module mfdf_ring
  import mfdf_pkg::*;
#(
  parameter int ID_CAPACITY = 64,
  localparam int IDX_W = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1
) (
  input  logic             clk_i,
  input  ring_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  output logic [ID_W-1:0]  head_id_o
);

  logic [ID_W-1:0] cell_id [ID_CAPACITY];

  for (genvar i = 0; i < ID_CAPACITY; i++) begin : g_cell
    logic cell_wr;
    assign cell_wr = ctrl_i.wr_en && (wr_idx_i == IDX_W'(i));

    // cell i takes from cell i+1; the last cell closes the ring
    mfdf_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctrl_i.shift),
      .shift_id_i (cell_id[(i + 1) % ID_CAPACITY]),
      .wr_en_i    (cell_wr),
      .wr_id_i    (ctrl_i.wr_id),
      .id_o       (cell_id[i])
    );
  end

  assign head_id_o = cell_id[0];

endmodule

// ===== rtl/mesh_flood_duplicate_filter.sv =====
// ============================================================================
// mesh_flood_duplicate_filter - duplicate suppression for flood-mesh messages
// Seen-ID ring with smallest-ID eviction, color set/sync with holdoff.
// ============================================================================
// A received message of correct length goes through these steps between one
// accept and the next: the beat is taken, the ring of ID cells rotates once
// through all ID_CAPACITY cells while the head cell is compared with the
// message ID and the running minimum, and the finish state writes the store
// and registers the result. A local-set event or a wrong-length message skips
// the rotation and goes straight from accept to the finish state. The result
// sits in an output register; the next beat is taken while it waits, and the
// finish state holds until that register is free. Stored IDs fill cells
// 0 upward and are never removed, only replaced, so a fill count marks which
// cells hold an ID and the store needs no clearing after reset. Configuration
// writes are meant for when the block is idle.
module mesh_flood_duplicate_filter
  import mfdf_pkg::*;
#(
  parameter int ID_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mfdf_in_if.sink               msg_i,
  mfdf_out_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
  localparam int CNT_W = $clog2(ID_CAPACITY + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [HOLDOFF_W-1:0] holdoff_q;
  logic [TYPE_W-1:0]    set_type_q;
  logic [TYPE_W-1:0]    sync_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q   <= HOLDOFF_RST;
      set_type_q  <= SET_TYPE_RST;
      sync_type_q <= SYNC_TYPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLDOFF:   holdoff_q   <= cfg_data_i[HOLDOFF_W-1:0];
        REG_SET_TYPE:  set_type_q  <= cfg_data_i[TYPE_W-1:0];
        REG_SYNC_TYPE: sync_type_q <= cfg_data_i[TYPE_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  fsm_e             state_d, state_q;
  item_t            item_d, item_q;
  logic [IDX_W-1:0] step_d, step_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             hit_d, hit_q;
  logic [ID_W-1:0]  min_d, min_q;
  logic [IDX_W-1:0] min_idx_d, min_idx_q;
  logic [TIME_W-1:0] last_set_d, last_set_q;
  logic             out_valid_d, out_valid_q;
  res_t             res_d, res_q;

  ring_ctrl_t       ring_ctrl;
  logic [IDX_W-1:0] wr_idx;
  logic [ID_W-1:0]  head_id;

  logic              in_fire;
  logic              commit;
  logic              head_valid;
  logic              last_step;
  logic              full;
  logic [TIME_W-1:0] expiry;
  res_t              res_new;

  mfdf_ring #(
    .ID_CAPACITY (ID_CAPACITY)
  ) u_ring (
    .clk_i     (clk_i),
    .ctrl_i    (ring_ctrl),
    .wr_idx_i  (wr_idx),
    .head_id_o (head_id)
  );

  assign msg_i.ready = (state_q == S_IDLE);
  assign in_fire     = msg_i.valid && msg_i.ready;

  // At scan step k the head holds cell k; cells below the fill count hold IDs
  assign head_valid = CNT_W'(step_q) < count_q;
  assign last_step  = (step_q == IDX_W'(ID_CAPACITY - 1));
  assign full       = (count_q == CNT_W'(ID_CAPACITY));
  assign expiry     = last_set_q + TIME_W'(holdoff_q);

  // Finish only when the output register is free or being emptied
  assign commit = (state_q == S_FINISH) && (!out_valid_q || res_o.ready);

  // Result of the held item, valid in the finish cycle
  always_comb begin
    res_new             = '0;
    res_new.status      = ST_UNKNOWN;
    priority if (item_q.op == OP_LOCAL_SET) begin
      res_new.status = ST_LOCAL_SET;
    end else if (!item_q.length_ok) begin
      res_new.status = ST_BAD_LENGTH;
    end else if (hit_q) begin
      res_new.status = ST_DUPLICATE;
    end else if (item_q.msg_type == set_type_q) begin
      // equal set and sync codes resolve as a set
      res_new.status      = ST_SET_APPLIED;
      res_new.apply_color = 1'b1;
      res_new.color_out   = item_q.color_value;
      res_new.rebroadcast = 1'b1;
    end else if (item_q.msg_type == sync_type_q) begin
      if (expiry < item_q.now_ms) begin
        res_new.status      = ST_SYNC_APPLIED;
        res_new.apply_color = 1'b1;
        res_new.color_out   = item_q.color_value;
      end else begin
        res_new.status = ST_SYNC_HELD;
      end
    end else begin
      res_new.status = ST_UNKNOWN;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    step_d      = step_q;
    count_d     = count_q;
    hit_d       = hit_q;
    min_d       = min_q;
    min_idx_d   = min_idx_q;
    last_set_d  = last_set_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    ring_ctrl       = '0;
    ring_ctrl.wr_id = item_q.message_id;
    wr_idx          = min_idx_q;

    // drain the output register
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d.op          = msg_i.op;
          item_d.length_ok   = msg_i.length_ok;
          item_d.msg_type    = msg_i.msg_type;
          item_d.color_value = msg_i.color_value;
          item_d.message_id  = msg_i.message_id;
          item_d.now_ms      = msg_i.now_ms;
          step_d             = '0;
          hit_d              = 1'b0;
          // local sets and bad lengths leave the store alone
          if ((msg_i.op == OP_LOCAL_SET) || !msg_i.length_ok) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // rotate every cycle; after a full turn the ring is back in place
        ring_ctrl.shift = 1'b1;
        if (head_valid) begin
          if (head_id == item_q.message_id) begin
            hit_d = 1'b1;
          end
          if ((step_q == '0) || (head_id < min_q)) begin
            min_d     = head_id;
            min_idx_d = step_q;
          end
        end
        if (last_step) begin
          state_d = S_FINISH;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end

      S_FINISH: begin
        if (commit) begin
          if ((item_q.op == OP_RX) && item_q.length_ok && !hit_q) begin
            if (!full) begin
              // append at the first free cell
              ring_ctrl.wr_en = 1'b1;
              wr_idx          = count_q[IDX_W-1:0];
              count_d         = count_q + CNT_W'(1);
            end else if (min_q < item_q.message_id) begin
              // evict the smallest stored ID
              ring_ctrl.wr_en = 1'b1;
            end
          end
          if ((res_new.status == ST_LOCAL_SET) || (res_new.status == ST_SET_APPLIED)) begin
            last_set_d = item_q.now_ms;
          end
          res_d       = res_new;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      last_set_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      hit_q       <= hit_d;
      last_set_q  <= last_set_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    min_q     <= min_d;
    min_idx_q <= min_idx_d;
    res_q     <= res_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = res_q.status;
  assign res_o.apply_color = res_q.apply_color;
  assign res_o.color_out   = res_q.color_out;
  assign res_o.rebroadcast = res_q.rebroadcast;

endmodule

// ===== rtl/mfdf_checker.sv =====
// ============================================================================
// mfdf_checker - port-level checks of the mesh flood duplicate filter
// Result consistency and input channel behavior seen at the top level ports.
// ============================================================================
module mfdf_checker
  import mfdf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [2:0]         status_i,
  input logic               apply_color_i,
  input logic [COLOR_W-1:0] color_out_i,
  input logic               rebroadcast_i
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(color_out_i) && $stable(apply_color_i) && $stable(rebroadcast_i))
    else $error("result beat changed while stalled");

  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !apply_color_i |-> color_out_i == '0)
    else $error("color driven without apply");

  a_rebroadcast_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rebroadcast_i |-> status_i == ST_SET_APPLIED && apply_color_i)
    else $error("rebroadcast on a non-set result");

  a_local_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_LOCAL_SET |-> !apply_color_i && !rebroadcast_i)
    else $error("local set drove color or rebroadcast");

  // one beat in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second beat accepted during processing");

endmodule

bind mesh_flood_duplicate_filter mfdf_checker u_mfdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (msg_i.valid),
  .in_ready_i    (msg_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .apply_color_i (res_o.apply_color),
  .color_out_i   (res_o.color_out),
  .rebroadcast_i (res_o.rebroadcast)
);
